### design/c8x_pkg.sv
// Package for the CHIP-8 instruction executor.
// Holds the word type, the item kinds, the back-end states, the sizes and the font table.
// Used by every module of the design except c8x_ram; depends on nothing.
`default_nettype none
package c8x_pkg;

	localparam int MEM_BYTES = 4096;
	localparam int MEM_AW = 12;
	localparam int SCREEN_W = 64;
	localparam int SCREEN_H = 32;
	localparam int ROW_AW = 5;
	localparam int COL_AW = 6;
	localparam int STACK_DEPTH_DEF = 16;
	localparam int FONT_BYTES = 80;
	localparam logic [11:0] PC_RESET = 12'h200;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_EXEC  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] addr;
		logic [7:0]  wbyte;
		logic [15:0] keys;
		logic [7:0]  rnd;
	} item_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH_HI,
		ST_FETCH_LO,
		ST_READ_X,
		ST_READ_Y,
		ST_EXEC,
		ST_WR_VF,
		ST_BCD_1,
		ST_BCD_2,
		ST_STORE_RD,
		ST_STORE_WR,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_DRAW_RD,
		ST_DRAW_WR,
		ST_DISP_RD
	} state_t;

	localparam logic [7:0] FONT [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

endpackage
`default_nettype wire

### design/c8x_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for main memory, the data registers and the frame buffer; no dependencies.
`default_nettype none
module c8x_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

### design/c8x_front.sv
// Front end: accepts input words, classifies them by kind and queues them.
// Depends on c8x_pkg; feeds c8x_back through a two-entry queue.
`default_nettype none
module c8x_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [47:0]    s_tdata,
	input  wire logic [1:0]     s_tuser,
	output c8x_pkg::item_t      head,
	output logic                head_valid,
	input  wire logic           pop
);
	import c8x_pkg::*;

	item_t      q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	item_t      item_in;

	always_comb begin
		case (s_tuser)
			2'd0:    item_in.kind = KIND_WRITE;
			2'd1:    item_in.kind = KIND_EXEC;
			2'd2:    item_in.kind = KIND_READ;
			default: item_in.kind = KIND_NONE;
		endcase
		item_in.addr  = s_tdata[11:0];
		item_in.wbyte = s_tdata[19:12];
		item_in.keys  = s_tdata[35:20];
		item_in.rnd   = s_tdata[43:36];
	end

	assign s_tready   = (count_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign head_valid = (count_q != 2'd0);
	assign head       = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/c8x_back.sv
// Back end: sequencer that carries out queued items state by state.
// Depends on c8x_pkg and c8x_ram; holds all machine state and the output register.
`default_nettype none
module c8x_back #(
	parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire c8x_pkg::item_t head,
	input  wire logic           head_valid,
	output logic                pop,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [23:0]         m_tdata
);
	import c8x_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH);

	state_t state_q, state_d;

	logic [MEM_AW-1:0] clr_q;
	logic [11:0] pc_q, pc_d;
	logic [15:0] index_q;
	logic [7:0]  dt_q, dt_d, st_q, st_d;
	logic [SPW-1:0] sp_q, sp_dec, sp_inc;
	logic [11:0] stack_q [STACK_DEPTH];
	logic [SCREEN_H-1:0] fb_valid_q;
	logic [7:0]  hi_q, vx_q, vy_q;
	logic [15:0] op_q;
	logic [15:0] keys_q;
	logic [7:0]  rnd_q;
	logic [11:0] daddr_q;
	logic [3:0]  cnt_q;
	logic [ROW_AW-1:0] row_q;
	logic        flag_q, scr_q;
	logic        out_valid_q;
	logic [23:0] out_q;

	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata, mem_rdata;
	logic              v_we;
	logic [3:0]        v_waddr, v_raddr;
	logic [7:0]        v_wdata, v_rdata;
	logic              fb_we;
	logic [ROW_AW-1:0] fb_waddr, fb_raddr;
	logic [SCREEN_W-1:0] fb_wdata, fb_rdata;

	logic        start, fin;
	logic [7:0]  res_rd;
	logic        res_wait, res_scr;

	logic [3:0]  op_x, op_y, op_n;
	logic [7:0]  op_nn;
	logic [11:0] op_nnn, pc2, mem_ix;
	logic [1:0]  bcd_h;
	logic [3:0]  bcd_t, bcd_o;
	logic        key_hit, key_any;
	logic [3:0]  key_top;
	logic [SCREEN_W-1:0] fb_old, draw_mask;
	logic        last_mv, last_row;

	state_t      ex_next;
	logic [11:0] ex_pc;
	logic        ex_vwe, ex_vf, ex_i_we, ex_push, ex_pop, ex_clear, ex_wait, ex_scr;
	logic        ex_mwe, ex_dset, ex_sset;
	logic [7:0]  ex_vdata, ex_mdata;
	logic [15:0] ex_i;

	c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	c8x_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata)
	);

	c8x_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_fb (
		.clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
		.raddr(fb_raddr), .rdata(fb_rdata)
	);

	assign op_x   = op_q[11:8];
	assign op_y   = op_q[7:4];
	assign op_n   = op_q[3:0];
	assign op_nn  = op_q[7:0];
	assign op_nnn = op_q[11:0];
	assign pc2    = pc_q + 12'd2;
	assign mem_ix = index_q[11:0] + 12'(cnt_q);
	assign sp_dec = (sp_q == '0) ? SPW'(STACK_DEPTH - 1) : sp_q - 1'b1;
	assign sp_inc = (sp_q == SPW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	assign start  = head_valid && (!out_valid_q || m_tready);
	assign last_mv  = (cnt_q == op_x);
	assign last_row = (cnt_q == op_n - 4'd1);
	assign key_hit  = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];
	assign fb_old   = fb_valid_q[row_q] ? fb_rdata : '0;

	always_comb begin
		logic [7:0]  rem;
		logic [14:0] prod;
		bcd_h = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
		rem   = vx_q - 8'd100 * 8'(bcd_h);
		prod  = 15'(rem) * 15'd205;
		bcd_t = prod[14:11];
		bcd_o = 4'(rem - 8'(bcd_t) * 8'd10);
	end

	always_comb begin
		key_any = |keys_q;
		key_top = 4'd0;
		for (int k = 0; k < 16; k++) begin
			if (keys_q[k]) begin
				key_top = 4'(k);
			end
		end
	end

	always_comb begin
		logic [COL_AW-1:0] col;
		draw_mask = '0;
		for (int c = 0; c < 8; c++) begin
			col = vx_q[COL_AW-1:0] + COL_AW'(c);
			if (mem_rdata[7-c]) begin
				draw_mask[col] = 1'b1;
			end
		end
	end

	always_comb begin
		ex_next  = ST_IDLE;
		ex_pc    = pc2;
		ex_vwe   = 1'b0;
		ex_vdata = '0;
		ex_vf    = 1'b0;
		ex_i_we  = 1'b0;
		ex_i     = index_q;
		ex_push  = 1'b0;
		ex_pop   = 1'b0;
		ex_clear = 1'b0;
		ex_wait  = 1'b0;
		ex_scr   = 1'b0;
		ex_mwe   = 1'b0;
		ex_mdata = '0;
		ex_dset  = 1'b0;
		ex_sset  = 1'b0;
		case (op_q[15:12])
			4'h0: begin
				if (op_q == 16'h00E0) begin
					ex_clear = 1'b1;
					ex_scr   = 1'b1;
				end else if (op_q == 16'h00EE) begin
					ex_pop = 1'b1;
					ex_pc  = stack_q[sp_dec];
				end
			end
			4'h1: ex_pc = op_nnn;
			4'h2: begin
				ex_push = 1'b1;
				ex_pc   = op_nnn;
			end
			4'h3: if (vx_q == op_nn) ex_pc = pc_q + 12'd4;
			4'h4: if (vx_q != op_nn) ex_pc = pc_q + 12'd4;
			4'h5: if (vx_q == vy_q) ex_pc = pc_q + 12'd4;
			4'h6: begin
				ex_vwe   = 1'b1;
				ex_vdata = op_nn;
			end
			4'h7: begin
				ex_vwe   = 1'b1;
				ex_vdata = vx_q + op_nn;
			end
			4'h8: begin
				case (op_n)
					4'h0: begin ex_vwe = 1'b1; ex_vdata = vy_q; end
					4'h1: begin ex_vwe = 1'b1; ex_vdata = vx_q | vy_q; end
					4'h2: begin ex_vwe = 1'b1; ex_vdata = vx_q & vy_q; end
					4'h3: begin ex_vwe = 1'b1; ex_vdata = vx_q ^ vy_q; end
					4'h4: begin
						ex_vwe = 1'b1;
						{ex_vf, ex_vdata} = {1'b0, vx_q} + {1'b0, vy_q};
						ex_next = ST_WR_VF;
					end
					4'h5: begin
						ex_vwe   = 1'b1;
						ex_vdata = vx_q - vy_q;
						ex_vf    = (vx_q >= vy_q);
						ex_next  = ST_WR_VF;
					end
					4'h6: begin
						ex_vwe   = 1'b1;
						ex_vdata = {1'b0, vx_q[7:1]};
						ex_vf    = vx_q[0];
						ex_next  = ST_WR_VF;
					end
					4'h7: begin
						ex_vwe   = 1'b1;
						ex_vdata = vy_q - vx_q;
						ex_vf    = (vy_q >= vx_q);
						ex_next  = ST_WR_VF;
					end
					4'hE: begin
						ex_vwe   = 1'b1;
						ex_vdata = {vx_q[6:0], 1'b0};
						ex_vf    = vx_q[7];
						ex_next  = ST_WR_VF;
					end
					default: ex_vwe = 1'b0;
				endcase
			end
			4'h9: if (vx_q != vy_q) ex_pc = pc_q + 12'd4;
			4'hA: begin
				ex_i_we = 1'b1;
				ex_i    = {4'd0, op_nnn};
			end
			4'hB: ex_pc = op_nnn + 12'(vy_q);
			4'hC: begin
				ex_vwe   = 1'b1;
				ex_vdata = rnd_q & op_nn;
			end
			4'hD: begin
				ex_scr  = 1'b1;
				ex_next = (op_n == 4'd0) ? ST_WR_VF : ST_DRAW_RD;
			end
			4'hE: begin
				if (op_nn == 8'h9E && key_hit) begin
					ex_pc = pc_q + 12'd4;
				end else if (op_nn == 8'hA1 && !key_hit) begin
					ex_pc = pc_q + 12'd4;
				end
			end
			default: begin
				case (op_nn)
					8'h07: begin ex_vwe = 1'b1; ex_vdata = dt_q; end
					8'h0A: begin
						if (key_any) begin
							ex_vwe   = 1'b1;
							ex_vdata = {4'd0, key_top};
						end else begin
							ex_pc   = pc_q;
							ex_wait = 1'b1;
						end
					end
					8'h15: ex_dset = 1'b1;
					8'h18: ex_sset = 1'b1;
					8'h1E: begin ex_i_we = 1'b1; ex_i = index_q + 16'(vx_q); end
					8'h29: begin ex_i_we = 1'b1; ex_i = 16'(7'd5 * 7'(vx_q[3:0])); end
					8'h33: begin
						ex_mwe   = 1'b1;
						ex_mdata = {6'd0, bcd_h};
						ex_next  = ST_BCD_1;
					end
					8'h55: ex_next = ST_STORE_RD;
					8'h65: ex_next = ST_LOAD_RD;
					default: ex_vwe = 1'b0;
				endcase
			end
		endcase
	end

	always_comb begin
		logic [7:0] dt_b, st_b;
		dt_b = ex_dset ? vx_q : dt_q;
		st_b = ex_sset ? vx_q : st_q;
		if (state_q == ST_EXEC) begin
			pc_d = ex_pc;
			dt_d = (dt_b != 8'd0) ? dt_b - 8'd1 : dt_b;
			st_d = (st_b != 8'd0) ? st_b - 8'd1 : st_b;
		end else begin
			pc_d = pc_q;
			dt_d = dt_q;
			st_d = st_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:    if (clr_q == MEM_AW'(MEM_BYTES - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (start) begin
					case (head.kind)
						KIND_EXEC: state_d = ST_FETCH_HI;
						KIND_READ: state_d = ST_DISP_RD;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_FETCH_HI: state_d = ST_FETCH_LO;
			ST_FETCH_LO: state_d = ST_READ_X;
			ST_READ_X:   state_d = ST_READ_Y;
			ST_READ_Y:   state_d = ST_EXEC;
			ST_EXEC:     state_d = ex_next;
			ST_BCD_1:    state_d = ST_BCD_2;
			ST_STORE_RD: state_d = ST_STORE_WR;
			ST_STORE_WR: state_d = last_mv ? ST_IDLE : ST_STORE_RD;
			ST_LOAD_RD:  state_d = ST_LOAD_WR;
			ST_LOAD_WR:  state_d = last_mv ? ST_IDLE : ST_LOAD_RD;
			ST_DRAW_RD:  state_d = ST_DRAW_WR;
			ST_DRAW_WR:  state_d = last_row ? ST_WR_VF : ST_DRAW_RD;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		fin       = 1'b0;
		res_rd    = '0;
		res_wait  = 1'b0;
		res_scr   = scr_q;
		mem_we    = 1'b0;
		mem_waddr = mem_ix;
		mem_wdata = '0;
		mem_raddr = mem_ix;
		v_we      = 1'b0;
		v_waddr   = op_x;
		v_wdata   = '0;
		v_raddr   = cnt_q;
		fb_we     = 1'b0;
		fb_waddr  = row_q;
		fb_wdata  = fb_old ^ draw_mask;
		fb_raddr  = head.addr[7:3];
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q < MEM_AW'(FONT_BYTES)) ? FONT[clr_q[6:0]] : 8'd0;
				v_we      = 1'b1;
				v_waddr   = clr_q[3:0];
			end
			ST_IDLE: begin
				pop       = start;
				res_scr   = 1'b0;
				mem_raddr = pc_q;
				if (start) begin
					case (head.kind)
						KIND_WRITE: begin
							mem_we    = 1'b1;
							mem_waddr = head.addr;
							mem_wdata = head.wbyte;
							fin       = 1'b1;
						end
						KIND_NONE: fin = 1'b1;
						default:   fin = 1'b0;
					endcase
				end
			end
			ST_FETCH_HI: mem_raddr = pc_q + 12'd1;
			ST_FETCH_LO: v_raddr = hi_q[3:0];
			ST_READ_X:   v_raddr = (op_q[15:12] == 4'hB) ? 4'd0 : op_y;
			ST_EXEC: begin
				v_we      = ex_vwe;
				v_wdata   = ex_vdata;
				mem_we    = ex_mwe;
				mem_waddr = index_q[11:0];
				mem_wdata = ex_mdata;
				fin       = (ex_next == ST_IDLE);
				res_wait  = ex_wait;
				res_scr   = ex_scr;
			end
			ST_WR_VF: begin
				v_we    = 1'b1;
				v_waddr = 4'hF;
				v_wdata = {7'd0, flag_q};
				fin     = 1'b1;
			end
			ST_BCD_1: begin
				mem_we    = 1'b1;
				mem_waddr = index_q[11:0] + 12'd1;
				mem_wdata = {4'd0, bcd_t};
			end
			ST_BCD_2: begin
				mem_we    = 1'b1;
				mem_waddr = index_q[11:0] + 12'd2;
				mem_wdata = {4'd0, bcd_o};
				fin       = 1'b1;
			end
			ST_STORE_WR: begin
				mem_we    = 1'b1;
				mem_wdata = v_rdata;
				fin       = last_mv;
			end
			ST_LOAD_WR: begin
				v_we    = 1'b1;
				v_waddr = cnt_q;
				v_wdata = mem_rdata;
				fin     = last_mv;
			end
			ST_DRAW_RD: fb_raddr = vy_q[ROW_AW-1:0] + ROW_AW'(cnt_q);
			ST_DRAW_WR: fb_we = 1'b1;
			ST_DISP_RD: begin
				fin     = 1'b1;
				res_scr = 1'b0;
				if (daddr_q[11:8] == 4'd0) begin
					for (int j = 0; j < 8; j++) begin
						res_rd[7-j] = fb_valid_q[daddr_q[7:3]] &
							fb_rdata[{daddr_q[2:0], 3'(j)}];
					end
				end
			end
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			keys_q  <= head.keys;
			rnd_q   <= head.rnd;
			daddr_q <= head.addr;
		end
		if (state_q == ST_FETCH_HI) begin
			hi_q <= mem_rdata;
		end
		if (state_q == ST_FETCH_LO) begin
			op_q <= {hi_q, mem_rdata};
		end
		if (state_q == ST_READ_X) begin
			vx_q <= v_rdata;
		end
		if (state_q == ST_READ_Y) begin
			vy_q <= v_rdata;
		end
		if (state_q == ST_DRAW_RD) begin
			row_q <= vy_q[ROW_AW-1:0] + ROW_AW'(cnt_q);
		end
		if (fin) begin
			out_q <= {1'b0, res_scr, res_wait, (st_d != 8'd0), pc_d, res_rd};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pc_q        <= PC_RESET;
			index_q     <= '0;
			dt_q        <= '0;
			st_q        <= '0;
			sp_q        <= '0;
			fb_valid_q  <= '0;
			cnt_q       <= '0;
			flag_q      <= 1'b0;
			scr_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < STACK_DEPTH; s++) begin
				stack_q[s] <= '0;
			end
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			dt_q    <= dt_d;
			st_q    <= st_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_EXEC) begin
				cnt_q  <= '0;
				flag_q <= ex_vf;
				scr_q  <= ex_scr;
				if (ex_i_we) begin
					index_q <= ex_i;
				end
				if (ex_push) begin
					stack_q[sp_q] <= pc2;
					sp_q          <= sp_inc;
				end
				if (ex_pop) begin
					sp_q <= sp_dec;
				end
				if (ex_clear) begin
					fb_valid_q <= '0;
				end
			end
			if (state_q == ST_STORE_WR || state_q == ST_LOAD_WR) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (state_q == ST_DRAW_WR) begin
				cnt_q             <= cnt_q + 4'd1;
				fb_valid_q[row_q] <= 1'b1;
				flag_q            <= flag_q | (|(fb_old & draw_mask));
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
endmodule
`default_nettype wire

### design/chip8_instruction_executor.sv
// CHIP-8 instruction executor, top level.
// Depends on c8x_pkg, c8x_front, c8x_back and c8x_ram.
//
// Input words arrive on the s_ channel: s_tuser selects the kind (write a
// memory byte, execute one instruction, read a display byte, or do nothing)
// and s_tdata carries the rest. Every input word yields exactly one result word
// on the m_ channel, in order. A two-entry queue sits between the front end and
// the sequencer, and the result sits in an output register, so input words keep
// being taken while the receiver stalls, until the queue is full.
// Steps after a word leaves the queue: a memory write is done as it is taken, a
// display read fetches a frame-buffer row and then picks the byte, and an
// instruction fetches its two bytes, reads VX and VY, executes and then writes VF
// if it sets it; FX33 writes its digits in turn, FX55 and FX65 move V0 to VX one
// register at a time, and DXYN reads and writes one display row per sprite row.
// After reset the sequencer walks main memory once, loading the font and clearing
// the rest; words are queued but not carried out during that pass.
// Reset puts PC at 0x200 and clears the registers, timers, stack and display.
`default_nettype none
module chip8_instruction_executor #(
	parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// address[11:0], write_byte[19:12], key_mask[35:20], random_byte[43:36]
	input  wire logic [47:0] s_tdata,
	// opcode[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_byte[7:0], next_pc[19:8], sound_active[20], waiting_for_key[21],
	// screen_changed[22]
	output logic [23:0]      m_tdata
);
	import c8x_pkg::*;

	item_t head;
	logic  head_valid;
	logic  pop;

	c8x_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.head(head), .head_valid(head_valid), .pop(pop)
	);

	c8x_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .head_valid(head_valid), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);
endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the CHIP-8 instruction executor.
// It writes short programs into memory, executes them and reads the display back,
// while an in-bench model of the core predicts every result word. Depends on c8x_pkg.
`timescale 1ns / 100ps
module testbench;
	import c8x_pkg::*;

	localparam logic [3:0] GRP_SYS = 4'h0, GRP_JP = 4'h1, GRP_CALL = 4'h2, GRP_SE = 4'h3;
	localparam logic [3:0] GRP_SNE = 4'h4, GRP_SER = 4'h5, GRP_LD = 4'h6, GRP_ADD = 4'h7;
	localparam logic [3:0] GRP_ALU = 4'h8, GRP_SNER = 4'h9, GRP_LDI = 4'hA, GRP_JPV = 4'hB;
	localparam logic [3:0] GRP_RND = 4'hC, GRP_DRW = 4'hD, GRP_KEY = 4'hE, GRP_MISC = 4'hF;
	localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;
	localparam logic [15:0] INS_CLS = 16'h00E0, INS_RET = 16'h00EE;
	localparam logic [7:0] KEY_DOWN = 8'h9E, KEY_UP = 8'hA1;
	localparam logic [7:0] MX_GETDT = 8'h07, MX_WAITK = 8'h0A, MX_SETDT = 8'h15;
	localparam logic [7:0] MX_SETST = 8'h18, MX_ADDI = 8'h1E, MX_FONT = 8'h29;
	localparam logic [7:0] MX_BCD = 8'h33, MX_STORE = 8'h55, MX_LOAD = 8'h65;
	localparam int LIMIT_CYCLES = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [47:0] s_tdata;
	logic [1:0] s_tuser;
	logic [23:0] m_tdata;

	chip8_instruction_executor dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	// Model state of the core.
	logic [7:0] mem [MEM_BYTES];
	logic [7:0] vreg [16];
	logic [11:0] stk [16];
	logic [3:0] sp;
	logic [11:0] pc;
	logic [15:0] ireg;
	logic [7:0] dtimer, stimer;
	logic fb [SCREEN_W*SCREEN_H];

	item_t pending [$];
	logic [23:0] expected_words [$];
	int pushed_words = 0, accepted_words = 0, checked_words = 0, errors = 0;
	int draws = 0, key_waits = 0, cycles = 0;
	bit drv_calm = 0, mon_calm = 0;

	function automatic int unsigned pick_gap(bit calm);
		int unsigned d;
		d = $urandom_range(0, 99);
		if (calm || d < 55) return 0;
		if (d < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic model_reset();
		for (int i = 0; i < MEM_BYTES; i++) mem[i] = (i < FONT_BYTES) ? FONT[i] : 8'h00;
		for (int i = 0; i < 16; i++) begin
			vreg[i] = 0;
			stk[i] = 0;
		end
		for (int i = 0; i < SCREEN_W*SCREEN_H; i++) fb[i] = 0;
		sp = 0;
		pc = PC_RESET;
		ireg = 0;
		dtimer = 0;
		stimer = 0;
	endtask

	task automatic run_instruction(input logic [15:0] keys, input logic [7:0] rnd,
			output logic hold, output logic drew);
		logic [15:0] op;
		logic [3:0] x, y, n;
		logic [7:0] nn, vx, vy, line;
		logic [11:0] nnn, npc, a;
		logic [8:0] sum;
		logic hit, kd;
		int px, py, found;
		op = {mem[pc], mem[pc + 12'd1]};
		x = op[11:8];
		y = op[7:4];
		n = op[3:0];
		nn = op[7:0];
		nnn = op[11:0];
		vx = vreg[x];
		vy = vreg[y];
		npc = pc + 12'd2;
		hold = 0;
		drew = 0;
		case (op[15:12])
			GRP_SYS: begin
				if (op == INS_CLS) begin
					for (int i = 0; i < SCREEN_W*SCREEN_H; i++) fb[i] = 0;
					drew = 1;
				end else if (op == INS_RET) begin
					sp = sp - 4'd1;
					npc = stk[sp];
				end
			end
			GRP_JP: npc = nnn;
			GRP_CALL: begin
				stk[sp] = npc;
				sp = sp + 4'd1;
				npc = nnn;
			end
			GRP_SE: if (vx == nn) npc = npc + 12'd2;
			GRP_SNE: if (vx != nn) npc = npc + 12'd2;
			GRP_SER: if (vx == vy) npc = npc + 12'd2;
			GRP_LD: vreg[x] = nn;
			GRP_ADD: vreg[x] = vx + nn;
			GRP_ALU: begin
				case (n)
					ALU_MOV: vreg[x] = vy;
					ALU_OR: vreg[x] = vx | vy;
					ALU_AND: vreg[x] = vx & vy;
					ALU_XOR: vreg[x] = vx ^ vy;
					ALU_ADD: begin
						sum = vx + vy;
						vreg[x] = sum[7:0];
						vreg[15] = {7'd0, sum[8]};
					end
					ALU_SUB: begin
						vreg[x] = vx - vy;
						vreg[15] = {7'd0, vx >= vy};
					end
					ALU_SHR: begin
						vreg[x] = vx >> 1;
						vreg[15] = {7'd0, vx[0]};
					end
					ALU_SUBN: begin
						vreg[x] = vy - vx;
						vreg[15] = {7'd0, vy >= vx};
					end
					ALU_SHL: begin
						vreg[x] = vx << 1;
						vreg[15] = {7'd0, vx[7]};
					end
					default: ;
				endcase
			end
			GRP_SNER: if (vx != vy) npc = npc + 12'd2;
			GRP_LDI: ireg = {4'd0, nnn};
			GRP_JPV: npc = nnn + {4'd0, vreg[0]};
			GRP_RND: vreg[x] = rnd & nn;
			GRP_DRW: begin
				hit = 0;
				for (int r = 0; r < n; r++) begin
					a = ireg[11:0] + 12'(r);
					line = mem[a];
					py = (vy + r) % SCREEN_H;
					for (int c = 0; c < 8; c++) begin
						if (line[7-c]) begin
							px = (vx + c) % SCREEN_W;
							if (fb[px + py*SCREEN_W]) hit = 1;
							fb[px + py*SCREEN_W] = ~fb[px + py*SCREEN_W];
						end
					end
				end
				vreg[15] = {7'd0, hit};
				drew = 1;
			end
			GRP_KEY: begin
				kd = (vx < 16) && keys[vx[3:0]];
				if (nn == KEY_DOWN && kd) npc = npc + 12'd2;
				else if (nn == KEY_UP && !kd) npc = npc + 12'd2;
			end
			default: begin
				case (nn)
					MX_GETDT: vreg[x] = dtimer;
					MX_WAITK: begin
						found = -1;
						for (int k = 15; k >= 0 && found < 0; k--) if (keys[k]) found = k;
						if (found < 0) begin
							npc = pc;
							hold = 1;
						end else begin
							vreg[x] = 8'(found);
						end
					end
					MX_SETDT: dtimer = vx;
					MX_SETST: stimer = vx;
					MX_ADDI: ireg = ireg + {8'd0, vx};
					MX_FONT: ireg = 16'd5 * {12'd0, vx[3:0]};
					MX_BCD: begin
						mem[ireg[11:0]] = 8'(vx / 100);
						mem[ireg[11:0] + 12'd1] = 8'((vx / 10) % 10);
						mem[ireg[11:0] + 12'd2] = 8'(vx % 10);
					end
					MX_STORE: for (int i = 0; i <= x; i++) mem[ireg[11:0] + 12'(i)] = vreg[i];
					MX_LOAD: for (int i = 0; i <= x; i++) vreg[i] = mem[ireg[11:0] + 12'(i)];
					default: ;
				endcase
			end
		endcase
		pc = npc;
		if (dtimer != 0) dtimer--;
		if (stimer != 0) stimer--;
	endtask

	task automatic predict_word(input item_t it);
		logic [7:0] rd;
		logic hold, drew;
		rd = 0;
		hold = 0;
		drew = 0;
		case (it.kind)
			KIND_WRITE: mem[it.addr] = it.wbyte;
			KIND_EXEC: begin
				run_instruction(it.keys, it.rnd, hold, drew);
				draws += drew;
				key_waits += hold;
			end
			KIND_READ: if (it.addr < SCREEN_W*SCREEN_H/8)
				for (int b = 0; b < 8; b++) rd = {rd[6:0], fb[it.addr*8 + b]};
			default: ;
		endcase
		expected_words.push_back({1'b0, drew, hold, stimer != 0, pc, rd});
	endtask

	task automatic report(input string field, input logic [11:0] want, input logic [11:0] got);
		errors++;
		$display("mismatch on word %0d, %s: expected %h, got %h", checked_words, field, want, got);
	endtask

	// Driver.
	item_t cur;
	int unsigned drv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= KIND_WRITE;
			drv_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				predict_word(cur);
				accepted_words++;
			end
			if ($urandom_range(0, 199) == 0) drv_calm = ~drv_calm;
			if (drv_gap > 0) begin
				drv_gap--;
				s_tvalid <= 1'b0;
			end else if (pending.size() > 0) begin
				cur = pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {4'd0, cur.rnd, cur.keys, cur.wbyte, cur.addr};
				s_tuser <= cur.kind;
				drv_gap = pick_gap(drv_calm);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor.
	logic [23:0] want;
	int unsigned mon_stall;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			mon_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("result word %h arrived with nothing expected", m_tdata);
				end else begin
					want = expected_words.pop_front();
					if (m_tdata[7:0] != want[7:0])
						report("read_byte", 12'(want[7:0]), 12'(m_tdata[7:0]));
					if (m_tdata[19:8] != want[19:8]) report("next_pc", want[19:8], m_tdata[19:8]);
					if (m_tdata[20] != want[20])
						report("sound_active", 12'(want[20]), 12'(m_tdata[20]));
					if (m_tdata[21] != want[21])
						report("waiting_for_key", 12'(want[21]), 12'(m_tdata[21]));
					if (m_tdata[22] != want[22])
						report("screen_changed", 12'(want[22]), 12'(m_tdata[22]));
				end
				checked_words++;
			end
			if ($urandom_range(0, 199) == 0) mon_calm = ~mon_calm;
			if (mon_stall > 0) begin
				mon_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				mon_stall = pick_gap(mon_calm);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic push_word(input kind_t k, input logic [11:0] a, input logic [7:0] wb,
			input logic [15:0] keys, input logic [7:0] rnd);
		item_t it;
		it.kind = k;
		it.addr = a;
		it.wbyte = wb;
		it.keys = keys;
		it.rnd = rnd;
		pending.push_back(it);
		pushed_words++;
	endtask

	// Places one instruction at the current PC and executes it.
	task automatic run_op(input logic [15:0] op, input logic [15:0] keys, input logic [7:0] rnd);
		wait (accepted_words == pushed_words);
		@(posedge clk);
		push_word(KIND_WRITE, pc, op[15:8], 16'h0000, 8'h00);
		push_word(KIND_WRITE, pc + 12'd1, op[7:0], 16'h0000, 8'h00);
		push_word(KIND_EXEC, 12'h000, 8'h00, keys, rnd);
	endtask

	function automatic logic [15:0] random_op();
		logic [15:0] op;
		logic [7:0] fx [10];
		fx = '{MX_GETDT, MX_WAITK, MX_SETDT, MX_SETST, MX_ADDI, MX_FONT, MX_BCD,
			MX_STORE, MX_LOAD, 8'h00};
		op = 16'($urandom);
		case (op[15:12])
			GRP_SYS: case ($urandom_range(0, 2))
				0: op = INS_CLS;
				1: op = INS_RET;
				default: ;
			endcase
			GRP_LD: if ($urandom_range(0, 1)) op[7:0] = 8'($urandom_range(0, 15));
			GRP_ALU: if ($urandom_range(0, 7) != 0)
				op[3:0] = (op[3] && op[2]) ? ALU_SHL : {1'b0, op[2:0]};
			GRP_DRW: if ($urandom_range(0, 3) != 0) op[3:0] = 4'($urandom_range(0, 5));
			GRP_KEY: if ($urandom_range(0, 5) != 0) op[7:0] = op[0] ? KEY_DOWN : KEY_UP;
			GRP_MISC: begin
				fx[9] = op[7:0];
				op[7:0] = fx[$urandom_range(0, 9)];
				if (op[7:0] == MX_STORE || op[7:0] == MX_LOAD)
					op[11:8] = 4'($urandom_range(0, 15));
			end
			default: ;
		endcase
		return op;
	endfunction

	initial begin
		logic [15:0] keys;
		model_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		push_word(KIND_WRITE, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
		push_word(KIND_READ, 12'hFFF, 8'h00, 16'h0000, 8'h00);
		push_word(KIND_NONE, 12'hABC, 8'h5A, 16'hFFFF, 8'hFF);
		run_op(16'h6FFF, 16'h0000, 8'h00);
		run_op(16'h8FF4, 16'h0000, 8'h00);
		run_op(16'hF00A, 16'h0000, 8'h00);
		run_op(16'hD01F, 16'hFFFF, 8'hFF);
		push_word(KIND_READ, 12'h000, 8'h00, 16'h0000, 8'h00);
		run_op(INS_CLS, 16'h8000, 8'h00);
		run_op(16'hFF55, 16'h0001, 8'h00);

		while (pushed_words < 1550) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: push_word(KIND_WRITE, 12'($urandom), 8'($urandom), 16'($urandom),
						8'($urandom));
					1: push_word(KIND_READ, 12'($urandom_range(0, 255)), 8'($urandom),
						16'($urandom), 8'($urandom));
					2: push_word(KIND_READ, 12'($urandom), 8'($urandom), 16'($urandom),
						8'($urandom));
					default: push_word(KIND_NONE, 12'($urandom), 8'($urandom), 16'($urandom),
						8'($urandom));
				endcase
			end else begin
				keys = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
				run_op(random_op(), keys, 8'($urandom));
			end
		end

		wait (accepted_words == pushed_words && expected_words.size() == 0);
		repeat (60) @(posedge clk);
		$display("ran %0d words (%0d display updates, %0d key waits), %0d results checked",
			accepted_words, draws, key_waits, checked_words);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

### filelist.f
design/c8x_pkg.sv
design/c8x_ram.sv
design/c8x_front.sv
design/c8x_back.sv
design/chip8_instruction_executor.sv
tb/sv/testbench.sv
